@@ rtl/pdct_pkg.sv @@
// ----------------------------------------------------------------------------
// pdct_pkg
// Shared field widths, command codes, register indexes and types of the
// Poisson-disk candidate table.
// ----------------------------------------------------------------------------
package pdct_pkg;

    localparam int CMD_W    = 2;
    localparam int VERTEX_W = 10;
    localparam int DIST_W   = 24;
    localparam int VCOUNT_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    // command codes
    localparam logic [CMD_W-1:0] CMD_REPORT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SELECT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VCOUNT = 1'b1;

    // register reset values
    localparam logic [DIST_W-1:0]   RADIUS_RST = 24'd65536;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 11'd1024;

    // scan stream control, one entry per cycle
    typedef struct packed {
        logic valid;  // entry data on the read port this cycle
        logic first;  // entry is the first of the scan
    } t_scan_ctl;

    // scan status
    typedef struct packed {
        logic cand_found;
        logic uns_found;
    } t_scan_flags;

endpackage

@@ rtl/poisson_disk_candidate_table_core.sv @@
// ----------------------------------------------------------------------------
// poisson_disk_candidate_table_core
// Selection table of greedy Poisson-disk sampling over indexed vertices.
// ----------------------------------------------------------------------------
// All per-vertex state (unsupported mark, candidate mark, candidate distance)
// lives in one table RAM of MAX_VERTICES entries with a registered read. A
// command is taken when start is high and busy is low. A neighbor report is a
// read-modify-write of its entry. A select scans every entry through the RAM
// read port, one per cycle, then folds in the last entry and writes back the
// pick; on an empty table it answers without a scan. A restart rewrites every
// entry. After reset, a clearing pass holds busy high. A select's result
// appears on o_chosen_vertex / o_vertex_valid / o_all_done for exactly one
// cycle with o_valid high, in the cycle after the select finishes; the
// receiver cannot hold it off. Reports and restarts give no result.
// Configuration writes are always accepted and should be made only while the
// block is idle.
// ----------------------------------------------------------------------------
module poisson_disk_candidate_table_core #(
    parameter int MAX_VERTICES  = 1024,
    parameter int DISTANCE_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command request
    input  logic                              start,
    output logic                              busy,
    input  logic [pdct_pkg::CMD_W-1:0]        i_cmd,
    input  logic [pdct_pkg::VERTEX_W-1:0]     i_vertex,
    input  logic [pdct_pkg::DIST_W-1:0]       i_distance,
    // select result
    output logic                              o_valid,
    output logic [pdct_pkg::VERTEX_W-1:0]     o_chosen_vertex,
    output logic                              o_vertex_valid,
    output logic                              o_all_done,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pdct_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pdct_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import pdct_pkg::*;

    // table geometry
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int DW = (DISTANCE_BITS < DIST_W) ? DISTANCE_BITS : DIST_W;
    localparam int EW = DW + 2;  // {unsupported, candidate, distance}
    localparam int RW = $clog2(MAX_VERTICES + 1);
    localparam int CW = ((AW > VCOUNT_W) ? AW : VCOUNT_W) + 1;  // compare width

    // state codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SWEEP  = 3'd1;
    localparam logic [2:0] S_REPORT = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_PICK   = 3'd5;

    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);
    localparam logic [CW-1:0] MAX_EXT   = CW'(MAX_VERTICES);

    // control registers
    logic [2:0]          r_state, n_state;
    logic [AW-1:0]       r_addr, n_addr;
    logic                r_fill, n_fill;
    logic [RW-1:0]       r_remain, n_remain;
    t_scan_ctl           r_scan_ctl, n_scan_ctl;
    logic                r_valid, n_valid;
    // configuration
    logic [DW-1:0]       r_radius;
    logic [VCOUNT_W-1:0] r_vcount;
    // payload registers
    logic [AW-1:0]       r_scan_idx;
    logic [AW-1:0]       r_rep_addr, n_rep_addr;
    logic [DW-1:0]       r_rep_dist, n_rep_dist;
    logic [VERTEX_W-1:0] r_chosen, n_chosen;
    logic                r_vvalid, n_vvalid;
    logic                r_all_done, n_all_done;

    // table RAM ports
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [EW-1:0]       ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [EW-1:0]       ram_rdata;

    // scan unit
    t_scan_flags         scan_flags;
    logic [AW-1:0]       scan_cand_idx;
    logic [AW-1:0]       scan_uns_idx;

    // decoded fields
    logic                accept;
    logic [CW-1:0]       vtx_ext;
    logic                vtx_in_range;
    logic [CW-1:0]       vcount_ext;
    logic [CW-1:0]       vcount_sat;
    logic                ent_uns;
    logic                ent_cand;
    logic [DW-1:0]       ent_dist;
    logic [AW-1:0]       pick;
    logic                pick_found;
    logic [RW-1:0]       remain_after;
    logic [CW-1:0]       pick_ext;

    assign accept       = start && (r_state == S_IDLE);
    assign vtx_ext      = CW'(i_vertex);
    assign vtx_in_range = vtx_ext < MAX_EXT;
    assign vcount_ext   = CW'(r_vcount);
    // restart saturates the count at the table depth
    assign vcount_sat   = (vcount_ext > MAX_EXT) ? MAX_EXT : vcount_ext;

    assign ent_uns  = ram_rdata[EW-1];
    assign ent_cand = ram_rdata[EW-2];
    assign ent_dist = ram_rdata[DW-1:0];

    // candidates first, else the lowest unsupported vertex
    assign pick       = scan_flags.cand_found ? scan_cand_idx : scan_uns_idx;
    assign pick_found = scan_flags.cand_found || scan_flags.uns_found;
    assign pick_ext   = CW'(pick);

    // a candidate is always unsupported, so any pick lowers the count
    assign remain_after = pick_found ? (r_remain - RW'(1)) : r_remain;

    // the read port follows the incoming vertex while idle, else the sweep
    assign ram_raddr = (r_state == S_IDLE) ? vtx_ext[AW-1:0] : r_addr;

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_fill     = r_fill;
        n_remain   = r_remain;
        n_scan_ctl = '0;
        n_valid    = 1'b0;
        n_rep_addr = r_rep_addr;
        n_rep_dist = r_rep_dist;
        n_chosen   = r_chosen;
        n_vvalid   = r_vvalid;
        n_all_done = r_all_done;
        ram_we     = 1'b0;
        ram_waddr  = r_addr;
        ram_wdata  = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_REPORT: begin
                            // out-of-range vertices are dropped
                            if (vtx_in_range) begin
                                n_rep_addr = vtx_ext[AW-1:0];
                                n_rep_dist = i_distance[DW-1:0];
                                n_state    = S_REPORT;
                            end
                        end
                        CMD_SELECT: begin
                            if (r_remain == '0) begin
                                // empty table answers at once
                                n_valid    = 1'b1;
                                n_chosen   = '0;
                                n_vvalid   = 1'b0;
                                n_all_done = 1'b1;
                            end else begin
                                n_addr  = '0;
                                n_state = S_SCAN;
                            end
                        end
                        CMD_RESTART: begin
                            n_addr   = '0;
                            n_fill   = 1'b1;
                            n_remain = vcount_sat[RW-1:0];
                            n_state  = S_SWEEP;
                        end
                        default: begin
                            // unused command code, ignored
                        end
                    endcase
                end
            end

            S_SWEEP: begin
                // rewrite every entry: unsupported below the count on restart,
                // all clear after reset
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = {r_fill && (CW'(r_addr) < vcount_sat), 1'b0, DW'(0)};
                n_addr    = r_addr + AW'(1);
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end

            S_REPORT: begin
                ram_waddr = r_rep_addr;
                if (r_rep_dist < r_radius) begin
                    // inside the disk: supported, candidate dropped
                    ram_we    = 1'b1;
                    ram_wdata = {1'b0, 1'b0, r_rep_dist};
                    if (ent_uns) begin
                        n_remain = r_remain - RW'(1);
                    end
                end else if (ent_uns && (!ent_cand || ent_dist > r_rep_dist)) begin
                    // new candidate or a closer distance
                    ram_we    = 1'b1;
                    ram_wdata = {1'b1, 1'b1, r_rep_dist};
                end
                n_state = S_IDLE;
            end

            S_SCAN: begin
                // issue one read a cycle, scan unit sees it in the next cycle
                n_scan_ctl.valid = 1'b1;
                n_scan_ctl.first = (r_addr == '0);
                n_addr           = r_addr + AW'(1);
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = S_DRAIN;
                end
            end

            S_DRAIN: begin
                // last entry is being folded into the scan
                n_state = S_PICK;
            end

            S_PICK: begin
                ram_waddr = pick;
                ram_wdata = {1'b0, 1'b0, DW'(0)};
                ram_we    = pick_found;
                n_remain  = remain_after;
                n_valid    = 1'b1;
                n_chosen   = pick_found ? pick_ext[VERTEX_W-1:0] : '0;
                n_vvalid   = pick_found;
                n_all_done = (remain_after == '0);
                n_state    = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_SWEEP;
            r_addr     <= '0;
            r_fill     <= 1'b0;
            r_remain   <= '0;
            r_scan_ctl <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_fill     <= n_fill;
            r_remain   <= n_remain;
            r_scan_ctl <= n_scan_ctl;
            r_valid    <= n_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST[DW-1:0];
            r_vcount <= VCOUNT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RADIUS: r_radius <= i_cfg_data[DW-1:0];
                REG_VCOUNT: r_vcount <= i_cfg_data[VCOUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_scan_idx <= r_addr;
        r_rep_addr <= n_rep_addr;
        r_rep_dist <= n_rep_dist;
        r_chosen   <= n_chosen;
        r_vvalid   <= n_vvalid;
        r_all_done <= n_all_done;
    end

    pdct_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_VERTICES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pdct_scan #(
        .AW (AW),
        .DW (DW)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (r_scan_ctl),
        .i_index      (r_scan_idx),
        .i_uns        (ent_uns),
        .i_cand       (ent_cand),
        .i_dist       (ent_dist),
        .o_flags      (scan_flags),
        .o_cand_index (scan_cand_idx),
        .o_uns_index  (scan_uns_idx)
    );

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_chosen_vertex = r_chosen;
    assign o_vertex_valid  = r_vvalid;
    assign o_all_done      = r_all_done;
    assign o_cfg_ready     = 1'b1;

endmodule

@@ rtl/pdct_ram.sv @@
// ----------------------------------------------------------------------------
// pdct_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module pdct_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pdct_scan.sv @@
// ----------------------------------------------------------------------------
// pdct_scan
// Running search over a stream of table entries: least-distance candidate
// (lowest index on ties) and lowest unsupported vertex.
// ----------------------------------------------------------------------------
module pdct_scan #(
    parameter int AW = 10,
    parameter int DW = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  pdct_pkg::t_scan_ctl     i_ctl,
    input  logic [AW-1:0]           i_index,
    input  logic                    i_uns,
    input  logic                    i_cand,
    input  logic [DW-1:0]           i_dist,
    output pdct_pkg::t_scan_flags   o_flags,
    output logic [AW-1:0]           o_cand_index,
    output logic [AW-1:0]           o_uns_index
);
    import pdct_pkg::*;

    t_scan_flags     r_flags, n_flags;
    logic [AW-1:0]   r_cand_index, n_cand_index;
    logic [AW-1:0]   r_uns_index, n_uns_index;
    logic [DW-1:0]   r_best, n_best;
    t_scan_flags     prev;

    always_comb begin
        // the first entry starts a fresh search
        prev         = i_ctl.first ? '0 : r_flags;
        n_flags      = r_flags;
        n_cand_index = r_cand_index;
        n_uns_index  = r_uns_index;
        n_best       = r_best;
        if (i_ctl.valid) begin
            n_flags = prev;
            if (i_cand && (!prev.cand_found || i_dist < r_best)) begin
                n_flags.cand_found = 1'b1;
                n_cand_index       = i_index;
                n_best             = i_dist;
            end
            if (i_uns && !prev.uns_found) begin
                n_flags.uns_found = 1'b1;
                n_uns_index       = i_index;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
        r_cand_index <= n_cand_index;
        r_uns_index  <= n_uns_index;
        r_best       <= n_best;
    end

    assign o_flags      = r_flags;
    assign o_cand_index = r_cand_index;
    assign o_uns_index  = r_uns_index;

endmodule
